@@ hw/rtl/tmp_pkg.sv @@
// Shared types and constants for the trapezoid motion profile planner.
`timescale 1ns / 1ps

package tmp_pkg;

  localparam int SPD_W  = 32;
  localparam int LEN_W  = 33;
  localparam int A_W    = 34;
  localparam int SQ_W   = 64;
  localparam int RAD_W  = 68;
  localparam int ROOT_W = 34;

  localparam logic [SPD_W-1:0] ACC_RESET = 32'd65536000;

  typedef enum logic [1:0] {
    KIND_TRAP = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_RAMP = 2'd2,
    KIND_ZERO = 2'd3
  } kind_e;

  typedef struct packed {
    logic [LEN_W-1:0] m;
    logic             zero;
    logic [SPD_W-1:0] v0;
    logic [SPD_W-1:0] vc;
    logic [SPD_W-1:0] v1;
  } geo_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             zero;
    logic [SPD_W-1:0] v0;
    logic [SPD_W-1:0] vc;
    logic [SPD_W-1:0] v1;
  } acc_t;

  typedef struct packed {
    logic [A_W-1:0]   a;
    logic [LEN_W-1:0] len;
    logic             zero;
    logic [SPD_W-1:0] v0;
    logic [SPD_W-1:0] vc;
    logic [SPD_W-1:0] v1;
    logic [SQ_W-1:0]  sq0;
    logic [SQ_W-1:0]  sq1;
    logic [RAD_W-1:0] ve2;
    logic [RAD_W-1:0] tri_rad;
  } ramp_t;

  typedef struct packed {
    kind_e            kind;
    logic             d0z;
    logic [LEN_W-1:0] len;
    logic [A_W-1:0]   a;
    logic [SPD_W-1:0] v0;
    logic [SPD_W-1:0] vc;
    logic [SPD_W-1:0] v1;
    logic [SQ_W-1:0]  sq0;
    logic [SQ_W-1:0]  sq1;
    logic [SPD_W-1:0] t0s;
    logic [SPD_W-1:0] t1s;
    logic [SPD_W-1:0] d0s;
    logic [SPD_W-1:0] d1s;
    logic [LEN_W-1:0] cd;
  } shape_t;

  typedef struct packed {
    kind_e             kind;
    logic              d0z;
    logic [LEN_W-1:0]  len;
    logic [SPD_W-1:0]  v0;
    logic [SPD_W-1:0]  vc;
    logic [ROOT_W-1:0] r;
    logic [SPD_W-1:0]  t0s;
    logic [SPD_W-1:0]  t1s;
    logic [SPD_W-1:0]  d0s;
    logic [SPD_W-1:0]  d1s;
    logic [LEN_W-1:0]  cd;
  } fin_t;

endpackage

@@ hw/rtl/trapezoid_motion_profile.sv @@
// Top level of the trapezoid motion profile planner.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o    | start/end points, three speeds
//  out     | output    | out_valid_o / out_stall_i  | peak speed, ramps, plateau, kind
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | axis acceleration limit
//
// One item is taken every cycle while in_stall_o is low, that is, while no result waits on a stalled output.
// Each item passes through the chains of one-bit square root and divider cells.
// Reset empties the pipeline and loads the acceleration register with 1000.0.
// The whole pipeline holds while a result waits on a stalled output.
`timescale 1ns / 1ps

module trapezoid_motion_profile #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [31:0]       start_x_i,
  input  logic signed [31:0]       start_y_i,
  input  logic signed [31:0]       start_z_i,
  input  logic signed [31:0]       end_x_i,
  input  logic signed [31:0]       end_y_i,
  input  logic signed [31:0]       end_z_i,
  input  logic [31:0]              entry_speed_i,
  input  logic [31:0]              cruise_speed_i,
  input  logic [31:0]              exit_speed_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              peak_speed_o,
  output logic [31:0]              accel_time_o,
  output logic [31:0]              decel_time_o,
  output logic [31:0]              accel_distance_o,
  output logic [31:0]              decel_distance_o,
  output logic [31:0]              cruise_time_o,
  output logic [31:0]              cruise_distance_o,
  output tmp_pkg::kind_e           profile_kind_o
);

  import tmp_pkg::*;

  localparam int TNW = SPD_W + FRAC_BITS;
  localparam int NW2 = (RAD_W > ROOT_W + FRAC_BITS) ? RAD_W : ROOT_W + FRAC_BITS;

  function automatic logic [LEN_W-1:0] abs_diff(input logic [31:0] s, input logic [31:0] e);
    logic [LEN_W-1:0] d;
    d = {e[31], e} - {s[31], s};
    return d[LEN_W-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [SPD_W-1:0] sat32(input logic [RAD_W-1:0] v);
    return (|v[RAD_W-1:SPD_W]) ? '1 : v[SPD_W-1:0];
  endfunction

  logic             adv;
  logic [SPD_W-1:0] acc_q;
  logic [SPD_W-1:0] acc1;

  // Stage 1: axis deltas.
  logic             p1_vld_q;
  logic [LEN_W-1:0] p1_dx_q, p1_dy_q, p1_dz_q;
  logic [SPD_W-1:0] p1_v0_q, p1_vc_q, p1_v1_q;
  // Stage 2: squares and largest component.
  logic             p2_vld_q;
  logic [LEN_W-1:0] p2_m_q, m_d;
  logic [65:0]      p2_sqx_q, p2_sqy_q, p2_sqz_q;
  logic [SPD_W-1:0] p2_v0_q, p2_vc_q, p2_v1_q;
  // Stage 3: radicand of the length.
  logic             p3_vld_q;
  logic [65:0]      p3_sum_q;
  geo_t             p3_side_q;
  // Length root.
  logic             sq1_vld;
  logic [LEN_W-1:0] len_w;
  geo_t             sq1_side;
  // Stage 4: acceleration numerator.
  logic             p4_vld_q;
  logic [64:0]      p4_prod_q;
  logic [LEN_W-1:0] p4_m_q;
  acc_t             p4_side_q, p4_side_d;
  // Path acceleration.
  logic             dva_vld;
  logic [A_W-1:0]   a_w;
  acc_t             dva_side;
  // Stage 5: speed squares and products.
  logic             p5_vld_q;
  logic [SQ_W-1:0]  p5_sq0_q, p5_sqc_q, p5_sq1_q;
  logic [SPD_W-1:0] p5_dv0_q, p5_dv1_q;
  logic [66:0]      p5_al_q;
  logic [A_W-1:0]   p5_a_q;
  acc_t             p5_side_q;
  // Stage 6: ramp numerators and radicands.
  logic             p6_vld_q;
  logic [TNW-1:0]   p6_tn0_q, p6_tn1_q;
  logic [SQ_W-1:0]  p6_n0_q, p6_n1_q;
  logic [A_W:0]     p6_a2_q;
  ramp_t            p6_side_q, p6_side_d;
  logic [RAD_W-1:0] two_al;
  // First division group.
  logic             g1_vld;
  logic [A_W-1:0]   g1_t0, g1_t1, g1_d0, g1_d1;
  ramp_t            g1_side;
  // Stage 7: profile choice.
  logic             p7_vld_q;
  logic [RAD_W-1:0] p7_rad_q, rad_d;
  shape_t           p7_side_q, p7_side_d;
  logic [A_W:0]     dsum;
  logic [A_W:0]     cd_full;
  // Peak root.
  logic              sq2_vld;
  logic [ROOT_W-1:0] r_w;
  shape_t            sq2_side;
  // Stage 8: peak square and speed gaps.
  logic              p8_vld_q;
  logic [RAD_W-1:0]  p8_sqp_q;
  logic [ROOT_W-1:0] p8_dr0_q, p8_dr1_q, p8_r_q;
  shape_t            p8_side_q;
  logic [ROOT_W-1:0] v0x, v1x;
  // Stage 9: second division inputs.
  logic              p9_vld_q;
  logic [NW2-1:0]    p9_n1_q, p9_n2_q, p9_n3_q, p9_n4_q;
  logic [A_W-1:0]    p9_den1_q, p9_a_q;
  logic [A_W:0]      p9_a2_q;
  fin_t              p9_side_q, p9_side_d;
  logic [RAD_W-1:0]  sq0x, sq1x;
  // Second division group.
  logic              g2_vld;
  logic [31:0]       g2_q1, g2_q2, g2_q3, g2_q4;
  fin_t              g2_side;
  // Output register.
  logic              out_vld_q;
  logic [31:0]       out_peak_q, out_t0_q, out_t1_q, out_d0_q, out_d1_q, out_ct_q, out_cd_q;
  logic [31:0]       out_peak_d, out_t0_d, out_t1_d, out_d0_d, out_d1_d, out_ct_d, out_cd_d;
  kind_e             out_kind_q;

  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;
  assign acc1        = (acc_q == '0) ? SPD_W'(1) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ACC_RESET;
    end else if (cfg_valid_i) begin
      acc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      p7_vld_q  <= 1'b0;
      p8_vld_q  <= 1'b0;
      p9_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q  <= in_valid_i;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      p4_vld_q  <= sq1_vld;
      p5_vld_q  <= dva_vld;
      p6_vld_q  <= p5_vld_q;
      p7_vld_q  <= g1_vld;
      p8_vld_q  <= sq2_vld;
      p9_vld_q  <= p8_vld_q;
      out_vld_q <= g2_vld;
    end
  end

  always_comb begin
    m_d = (p1_dx_q > p1_dy_q) ? p1_dx_q : p1_dy_q;
    if (p1_dz_q > m_d) begin
      m_d = p1_dz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_dx_q <= abs_diff(start_x_i, end_x_i);
      p1_dy_q <= abs_diff(start_y_i, end_y_i);
      p1_dz_q <= abs_diff(start_z_i, end_z_i);
      p1_v0_q <= entry_speed_i;
      p1_vc_q <= cruise_speed_i;
      p1_v1_q <= exit_speed_i;

      p2_m_q   <= m_d;
      p2_sqx_q <= 66'(p1_dx_q) * 66'(p1_dx_q);
      p2_sqy_q <= 66'(p1_dy_q) * 66'(p1_dy_q);
      p2_sqz_q <= 66'(p1_dz_q) * 66'(p1_dz_q);
      p2_v0_q  <= p1_v0_q;
      p2_vc_q  <= p1_vc_q;
      p2_v1_q  <= p1_v1_q;

      p3_sum_q       <= p2_sqx_q + p2_sqy_q + p2_sqz_q;
      p3_side_q.m    <= p2_m_q;
      p3_side_q.zero <= (p2_m_q == '0);
      p3_side_q.v0   <= p2_v0_q;
      p3_side_q.vc   <= p2_vc_q;
      p3_side_q.v1   <= p2_v1_q;
    end
  end

  tmp_sqrt #(
    .NW(66),
    .SW($bits(geo_t))
  ) u_len_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p3_vld_q),
    .rad_i (p3_sum_q),
    .side_i(p3_side_q),
    .vld_o (sq1_vld),
    .root_o(len_w),
    .side_o(sq1_side)
  );

  always_comb begin
    p4_side_d.len  = len_w;
    p4_side_d.zero = sq1_side.zero;
    p4_side_d.v0   = sq1_side.v0;
    p4_side_d.vc   = sq1_side.vc;
    p4_side_d.v1   = sq1_side.v1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_prod_q <= 65'(acc1) * 65'(len_w);
      p4_m_q    <= sq1_side.m;
      p4_side_q <= p4_side_d;
    end
  end

  tmp_div #(
    .NW(65),
    .DW(LEN_W),
    .QW(A_W),
    .SW($bits(acc_t))
  ) u_acc_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p4_vld_q),
    .num_i (p4_prod_q),
    .den_i (p4_m_q),
    .side_i(p4_side_q),
    .vld_o (dva_vld),
    .quo_o (a_w),
    .side_o(dva_side)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_sq0_q  <= 64'(dva_side.v0) * 64'(dva_side.v0);
      p5_sqc_q  <= 64'(dva_side.vc) * 64'(dva_side.vc);
      p5_sq1_q  <= 64'(dva_side.v1) * 64'(dva_side.v1);
      p5_dv0_q  <= (dva_side.vc > dva_side.v0) ? dva_side.vc - dva_side.v0
                                               : dva_side.v0 - dva_side.vc;
      p5_dv1_q  <= (dva_side.v1 > dva_side.vc) ? dva_side.v1 - dva_side.vc
                                               : dva_side.vc - dva_side.v1;
      p5_al_q   <= 67'(a_w) * 67'(dva_side.len);
      p5_a_q    <= a_w;
      p5_side_q <= dva_side;
    end
  end

  always_comb begin
    two_al            = {p5_al_q, 1'b0};
    p6_side_d.a       = p5_a_q;
    p6_side_d.len     = p5_side_q.len;
    p6_side_d.zero    = p5_side_q.zero;
    p6_side_d.v0      = p5_side_q.v0;
    p6_side_d.vc      = p5_side_q.vc;
    p6_side_d.v1      = p5_side_q.v1;
    p6_side_d.sq0     = p5_sq0_q;
    p6_side_d.sq1     = p5_sq1_q;
    if (p5_side_q.v0 <= p5_side_q.v1) begin
      p6_side_d.ve2 = RAD_W'(p5_sq0_q) + two_al;
    end else if (RAD_W'(p5_sq0_q) > two_al) begin
      p6_side_d.ve2 = RAD_W'(p5_sq0_q) - two_al;
    end else begin
      p6_side_d.ve2 = '0;
    end
    p6_side_d.tri_rad = RAD_W'(p5_al_q)
                      + ((RAD_W'(p5_sq0_q) + RAD_W'(p5_sq1_q)) >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_tn0_q  <= TNW'(p5_dv0_q) << FRAC_BITS;
      p6_tn1_q  <= TNW'(p5_dv1_q) << FRAC_BITS;
      p6_n0_q   <= (p5_sqc_q >= p5_sq0_q) ? p5_sqc_q - p5_sq0_q : p5_sq0_q - p5_sqc_q;
      p6_n1_q   <= (p5_sq1_q >= p5_sqc_q) ? p5_sq1_q - p5_sqc_q : p5_sqc_q - p5_sq1_q;
      p6_a2_q   <= {p5_a_q, 1'b0};
      p6_side_q <= p6_side_d;
    end
  end

  tmp_div #(
    .NW(TNW),
    .DW(A_W),
    .QW(A_W),
    .SW($bits(ramp_t))
  ) u_t0_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p6_vld_q),
    .num_i (p6_tn0_q),
    .den_i (p6_side_q.a),
    .side_i(p6_side_q),
    .vld_o (g1_vld),
    .quo_o (g1_t0),
    .side_o(g1_side)
  );

  tmp_div #(
    .NW(TNW),
    .DW(A_W),
    .QW(A_W),
    .SW(1)
  ) u_t1_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p6_vld_q),
    .num_i (p6_tn1_q),
    .den_i (p6_side_q.a),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g1_t1),
    .side_o()
  );

  tmp_div #(
    .NW(SQ_W),
    .DW(A_W + 1),
    .QW(A_W),
    .SW(1)
  ) u_d0_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p6_vld_q),
    .num_i (p6_n0_q),
    .den_i (p6_a2_q),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g1_d0),
    .side_o()
  );

  tmp_div #(
    .NW(SQ_W),
    .DW(A_W + 1),
    .QW(A_W),
    .SW(1)
  ) u_d1_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p6_vld_q),
    .num_i (p6_n1_q),
    .den_i (p6_a2_q),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g1_d1),
    .side_o()
  );

  always_comb begin
    dsum    = (A_W + 1)'(g1_d0) + (A_W + 1)'(g1_d1);
    cd_full = (A_W + 1)'(g1_side.len) - dsum;
    if (g1_side.zero) begin
      p7_side_d.kind = KIND_ZERO;
    end else if (dsum <= (A_W + 1)'(g1_side.len)) begin
      p7_side_d.kind = KIND_TRAP;
    end else if ((g1_d0 == '0) || (g1_d1 == '0)) begin
      p7_side_d.kind = KIND_RAMP;
    end else begin
      p7_side_d.kind = KIND_TRI;
    end
    rad_d           = (p7_side_d.kind == KIND_RAMP) ? g1_side.ve2 : g1_side.tri_rad;
    p7_side_d.d0z   = (g1_d0 == '0);
    p7_side_d.len   = g1_side.len;
    p7_side_d.a     = g1_side.a;
    p7_side_d.v0    = g1_side.v0;
    p7_side_d.vc    = g1_side.vc;
    p7_side_d.v1    = g1_side.v1;
    p7_side_d.sq0   = g1_side.sq0;
    p7_side_d.sq1   = g1_side.sq1;
    p7_side_d.t0s   = sat32(RAD_W'(g1_t0));
    p7_side_d.t1s   = sat32(RAD_W'(g1_t1));
    p7_side_d.d0s   = sat32(RAD_W'(g1_d0));
    p7_side_d.d1s   = sat32(RAD_W'(g1_d1));
    p7_side_d.cd    = cd_full[LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p7_rad_q  <= rad_d;
      p7_side_q <= p7_side_d;
    end
  end

  tmp_sqrt #(
    .NW(RAD_W),
    .SW($bits(shape_t))
  ) u_peak_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p7_vld_q),
    .rad_i (p7_rad_q),
    .side_i(p7_side_q),
    .vld_o (sq2_vld),
    .root_o(r_w),
    .side_o(sq2_side)
  );

  assign v0x = ROOT_W'(sq2_side.v0);
  assign v1x = ROOT_W'(sq2_side.v1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p8_sqp_q  <= RAD_W'(r_w) * RAD_W'(r_w);
      p8_dr0_q  <= (r_w > v0x) ? r_w - v0x : v0x - r_w;
      p8_dr1_q  <= (r_w > v1x) ? r_w - v1x : v1x - r_w;
      p8_r_q    <= r_w;
      p8_side_q <= sq2_side;
    end
  end

  always_comb begin
    sq0x            = RAD_W'(p8_side_q.sq0);
    sq1x            = RAD_W'(p8_side_q.sq1);
    p9_side_d.kind  = p8_side_q.kind;
    p9_side_d.d0z   = p8_side_q.d0z;
    p9_side_d.len   = p8_side_q.len;
    p9_side_d.v0    = p8_side_q.v0;
    p9_side_d.vc    = p8_side_q.vc;
    p9_side_d.r     = p8_r_q;
    p9_side_d.t0s   = p8_side_q.t0s;
    p9_side_d.t1s   = p8_side_q.t1s;
    p9_side_d.d0s   = p8_side_q.d0s;
    p9_side_d.d1s   = p8_side_q.d1s;
    p9_side_d.cd    = p8_side_q.cd;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (p8_side_q.kind == KIND_TRAP) begin
        p9_n1_q   <= NW2'(p8_side_q.cd) << FRAC_BITS;
        p9_den1_q <= A_W'(p8_side_q.vc);
      end else begin
        p9_n1_q   <= NW2'(p8_dr0_q) << FRAC_BITS;
        p9_den1_q <= p8_side_q.a;
      end
      p9_n2_q   <= NW2'(p8_dr1_q) << FRAC_BITS;
      p9_n3_q   <= NW2'((p8_sqp_q >= sq0x) ? p8_sqp_q - sq0x : sq0x - p8_sqp_q);
      p9_n4_q   <= NW2'((p8_sqp_q >= sq1x) ? p8_sqp_q - sq1x : sq1x - p8_sqp_q);
      p9_a_q    <= p8_side_q.a;
      p9_a2_q   <= {p8_side_q.a, 1'b0};
      p9_side_q <= p9_side_d;
    end
  end

  tmp_div #(
    .NW(NW2),
    .DW(A_W),
    .QW(32),
    .SW($bits(fin_t))
  ) u_q1_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p9_vld_q),
    .num_i (p9_n1_q),
    .den_i (p9_den1_q),
    .side_i(p9_side_q),
    .vld_o (g2_vld),
    .quo_o (g2_q1),
    .side_o(g2_side)
  );

  tmp_div #(
    .NW(NW2),
    .DW(A_W),
    .QW(32),
    .SW(1)
  ) u_q2_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p9_vld_q),
    .num_i (p9_n2_q),
    .den_i (p9_a_q),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g2_q2),
    .side_o()
  );

  tmp_div #(
    .NW(NW2),
    .DW(A_W + 1),
    .QW(32),
    .SW(1)
  ) u_q3_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p9_vld_q),
    .num_i (p9_n3_q),
    .den_i (p9_a2_q),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g2_q3),
    .side_o()
  );

  tmp_div #(
    .NW(NW2),
    .DW(A_W + 1),
    .QW(32),
    .SW(1)
  ) u_q4_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (p9_vld_q),
    .num_i (p9_n4_q),
    .den_i (p9_a2_q),
    .side_i(1'b0),
    .vld_o (),
    .quo_o (g2_q4),
    .side_o()
  );

  always_comb begin
    out_peak_d = '0;
    out_t0_d   = '0;
    out_t1_d   = '0;
    out_d0_d   = '0;
    out_d1_d   = '0;
    out_ct_d   = '0;
    out_cd_d   = '0;
    case (g2_side.kind)
      KIND_TRAP: begin
        out_peak_d = g2_side.vc;
        out_t0_d   = g2_side.t0s;
        out_t1_d   = g2_side.t1s;
        out_d0_d   = g2_side.d0s;
        out_d1_d   = g2_side.d1s;
        out_cd_d   = sat32(RAD_W'(g2_side.cd));
        if (g2_side.vc != '0) begin
          out_ct_d = g2_q1;
        end else begin
          out_ct_d = (g2_side.cd != '0) ? '1 : '0;
        end
      end
      KIND_RAMP: begin
        out_peak_d = (g2_side.r > ROOT_W'(g2_side.v0)) ? sat32(RAD_W'(g2_side.r))
                                                        : g2_side.v0;
        if (g2_side.d0z) begin
          out_t1_d = g2_q1;
          out_d1_d = sat32(RAD_W'(g2_side.len));
        end else begin
          out_t0_d = g2_q1;
          out_d0_d = sat32(RAD_W'(g2_side.len));
        end
      end
      KIND_TRI: begin
        out_peak_d = sat32(RAD_W'(g2_side.r));
        out_t0_d   = g2_q1;
        out_t1_d   = g2_q2;
        out_d0_d   = g2_q3;
        out_d1_d   = g2_q4;
      end
      default: begin
        out_peak_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_peak_q <= out_peak_d;
      out_t0_q   <= out_t0_d;
      out_t1_q   <= out_t1_d;
      out_d0_q   <= out_d0_d;
      out_d1_q   <= out_d1_d;
      out_ct_q   <= out_ct_d;
      out_cd_q   <= out_cd_d;
      out_kind_q <= g2_side.kind;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign peak_speed_o      = out_peak_q;
  assign accel_time_o      = out_t0_q;
  assign decel_time_o      = out_t1_q;
  assign accel_distance_o  = out_d0_q;
  assign decel_distance_o  = out_d1_q;
  assign cruise_time_o     = out_ct_q;
  assign cruise_distance_o = out_cd_q;
  assign profile_kind_o    = out_kind_q;

endmodule

@@ hw/rtl/tmp_div_cell.sv @@
// One restoring division step: produces one quotient bit.
`timescale 1ns / 1ps

module tmp_div_cell #(
  parameter int DW = 33
) (
  input  logic [DW-1:0] rem_i,
  input  logic          bit_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic          q_o
);

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    r2    = {rem_i, bit_i};
    diff  = r2 - {1'b0, den_i};
    ge    = (r2 >= {1'b0, den_i});
    rem_o = ge ? diff[DW-1:0] : r2[DW-1:0];
    q_o   = ge;
  end

endmodule

@@ hw/rtl/tmp_sqrt_cell.sv @@
// One digit-by-digit square root step: produces one root bit.
`timescale 1ns / 1ps

module tmp_sqrt_cell #(
  parameter int RW = 33
) (
  input  logic [RW+1:0] rem_i,
  input  logic [1:0]    pair_i,
  input  logic [RW-1:0] root_i,
  output logic [RW+1:0] rem_o,
  output logic [RW-1:0] root_o
);

  logic [RW+3:0] r2;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  always_comb begin
    r2     = {rem_i, pair_i};
    trial  = {2'b00, root_i, 2'b01};
    diff   = r2 - trial;
    ge     = (r2 >= trial);
    rem_o  = ge ? diff[RW+1:0] : r2[RW+1:0];
    root_o = {root_i[RW-2:0], ge};
  end

endmodule

@@ hw/rtl/tmp_div.sv @@
// Pipelined saturating divider built as a chain of one-bit division cells.
`timescale 1ns / 1ps

module tmp_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 34,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_x;
  logic [CW-1:0] den_x;
  logic          ovf;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] low_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic          vld_q  [QW+1];

  logic [DW-1:0] rem_c  [QW];
  logic          q_c    [QW];

  always_comb begin
    hi_x  = CW'(num_i[NW-1:QW]);
    den_x = CW'(den_i);
    ovf   = (hi_x >= den_x);
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    tmp_div_cell #(
      .DW(DW)
    ) u_cell (
      .rem_i(rem_q[k]),
      .bit_i(low_q[k][QW-1]),
      .den_i(den_q[k]),
      .rem_o(rem_c[k]),
      .q_o  (q_c[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 0; k < QW; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(num_i[NW-1:QW]);
      low_q[0]  <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= ovf;
      side_q[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        rem_q[k+1]  <= rem_c[k];
        low_q[k+1]  <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][QW-2:0], q_c[k]};
        den_q[k+1]  <= den_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign quo_o  = ovf_q[QW] ? '1 : quo_q[QW];
  assign side_o = side_q[QW];

endmodule

@@ hw/rtl/tmp_sqrt.sv @@
// Pipelined integer square root built as a chain of one-bit root cells.
`timescale 1ns / 1ps

module tmp_sqrt #(
  parameter int NW = 66,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [NW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [NW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = NW / 2;

  logic [NW-1:0] rad_q  [RW+1];
  logic [RW+1:0] rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [SW-1:0] side_q [RW+1];
  logic          vld_q  [RW+1];

  logic [RW+1:0] rem_c  [RW];
  logic [RW-1:0] root_c [RW];

  for (genvar k = 0; k < RW; k++) begin : g_cell
    tmp_sqrt_cell #(
      .RW(RW)
    ) u_cell (
      .rem_i (rem_q[k]),
      .pair_i(rad_q[k][NW-1:NW-2]),
      .root_i(root_q[k]),
      .rem_o (rem_c[k]),
      .root_o(root_c[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= RW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 0; k < RW; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < RW; k++) begin
        rad_q[k+1]  <= {rad_q[k][NW-3:0], 2'b00};
        rem_q[k+1]  <= rem_c[k];
        root_q[k+1] <= root_c[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign side_o = side_q[RW];

endmodule
